>>> hw/rtl/cfws_pkg.sv
// cfws_pkg: shared widths, command codes and the result record of the
// circular FIFO with search. No dependencies.
package cfws_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 11;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         position;
    logic [CNT_W-1:0]         occupancy;
  } res_t;

endpackage

>>> hw/rtl/cfws_if.sv
// Request and response channel interfaces of the circular FIFO with search.
// Depends on cfws_pkg.
interface cfws_req_if;
  logic                              valid;
  logic                              ready;
  logic [cfws_pkg::CMD_W-1:0]        cmd;
  logic signed [cfws_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cfws_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic signed [cfws_pkg::DATA_W-1:0] data;
  logic [cfws_pkg::CNT_W-1:0]         position;
  logic [cfws_pkg::CNT_W-1:0]         occupancy;

  modport source (output valid, output ok, output data, output position, output occupancy,
                  input ready);
  modport sink   (input valid, input ok, input data, input position, input occupancy,
                  output ready);
endinterface

>>> hw/rtl/cfws_ram.sv
// cfws_ram: entry storage, one write port and one registered read port.
// No dependencies.
module cfws_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low; the scan relies on that during stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/cfws_seq.sv
// cfws_seq: command sequencer with head/tail/count state, the shared 32-bit
// comparator used by the search scan, and the entry storage.
// Depends on cfws_pkg, cfws_if, cfws_ram.
module cfws_seq #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  cfws_req_if.sink                    req,
  input  logic [cfws_pkg::CNT_W-1:0]  capacity,
  input  logic                        cfg_clear,
  input  logic                        out_free,
  output logic                        done,
  output cfws_pkg::res_t              res
);

  localparam int CW   = cfws_pkg::CNT_W;
  localparam int DW   = cfws_pkg::DATA_W;
  localparam int CMPW = (AW + 1 > CW) ? AW + 1 : CW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state, state_next;
  logic [AW-1:0]        head, head_next;
  logic [AW-1:0]        tail, tail_next;
  logic [CW-1:0]        fill, fill_next;
  logic [AW-1:0]        scan_ptr, scan_ptr_next;
  logic [CW-1:0]        scan_n, scan_n_next;
  logic signed [DW-1:0] key, key_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;
  logic          fire;
  logic          hit;

  // wrap from capacity-1 back to slot 0
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx,
                                              input logic [CW-1:0] cap);
    logic [CMPW-1:0] inc;
    inc = CMPW'(idx) + CMPW'(1);
    if (inc >= CMPW'(cap)) begin
      return '0;
    end
    return AW'(inc);
  endfunction

  cfws_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready = (state == S_IDLE) && out_free;
  assign fire      = req.valid && req.ready;
  assign hit       = (rdata == key);

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    fill_next     = fill;
    scan_ptr_next = scan_ptr;
    scan_n_next   = scan_n;
    key_next      = key;
    we            = 1'b0;
    waddr         = tail;
    re            = 1'b0;
    raddr         = head;
    done          = 1'b0;
    res           = '0;
    res.occupancy = fill;

    unique case (state)
      S_IDLE: begin
        if (fire) begin
          unique case (req.cmd)
            cfws_pkg::CMD_PUSH: begin
              done = 1'b1;
              if (fill < capacity) begin
                res.ok        = 1'b1;
                we            = 1'b1;
                tail_next     = next_slot(tail, capacity);
                fill_next     = fill + CW'(1);
                res.occupancy = fill + CW'(1);
              end
            end
            cfws_pkg::CMD_POP: begin
              if (fill == '0) begin
                done = 1'b1;
              end else begin
                re         = 1'b1;
                state_next = S_POP;
              end
            end
            cfws_pkg::CMD_SEARCH: begin
              if (fill == '0) begin
                done   = 1'b1;
                res.ok = 1'b1;
              end else begin
                re            = 1'b1;
                scan_ptr_next = next_slot(head, capacity);
                scan_n_next   = CW'(1);
                key_next      = req.value;
                state_next    = S_SCAN;
              end
            end
            cfws_pkg::CMD_CLEAR: begin
              done          = 1'b1;
              res.ok        = 1'b1;
              head_next     = '0;
              tail_next     = '0;
              fill_next     = '0;
              res.occupancy = '0;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          done          = 1'b1;
          res.ok        = 1'b1;
          res.data      = rdata;
          head_next     = next_slot(head, capacity);
          fill_next     = fill - CW'(1);
          res.occupancy = fill - CW'(1);
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        // rdata holds entry number scan_n (1-based from head)
        if (hit || scan_n == fill) begin
          if (out_free) begin
            done         = 1'b1;
            res.ok       = 1'b1;
            res.position = hit ? scan_n : '0;
            state_next   = S_IDLE;
          end
        end else begin
          re            = 1'b1;
          raddr         = scan_ptr;
          scan_ptr_next = next_slot(scan_ptr, capacity);
          scan_n_next   = scan_n + CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cfg_clear) begin
      head_next = '0;
      tail_next = '0;
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr <= scan_ptr_next;
    scan_n   <= scan_n_next;
    key      <= key_next;
  end

endmodule

>>> hw/rtl/circular_fifo_with_search.sv
// circular_fifo_with_search: top level, capacity register and response
// register. Depends on cfws_pkg, cfws_if, cfws_seq.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd[1:0], value[31:0] signed
//   rsp      out  valid/ready    ok, data[31:0] signed, position[10:0], occupancy[10:0]
//   cfg      in   cfg_we         cfg_wdata[10:0] (capacity)
//
// Push, clear, failed pop and search on an empty queue are answered from the idle
// state; the result is in the response register at the next edge. Pop reads through
// the memory read port in S_POP. Search compares k entries, one per cycle through the
// single read port and the 32-bit comparator; k is at most the occupancy.
// Reset (rst, synchronous) empties the queue and sets capacity to DEPTH, at most 2047;
// storage is not cleared. A stalled response holds and blocks new requests.
module circular_fifo_with_search #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  cfws_req_if.sink                    req,
  cfws_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [cfws_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int CW      = cfws_pkg::CNT_W;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_MAX = (DEPTH < (2 ** CW) - 1) ? DEPTH : (2 ** CW) - 1;

  logic [CW-1:0]   capacity;
  logic            out_free;
  logic            done;
  cfws_pkg::res_t  res;
  cfws_pkg::res_t  res_q;

  assign out_free = !rsp.valid || rsp.ready;

  cfws_seq #(.DEPTH(DEPTH), .AW(AW)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .capacity  (capacity),
    .cfg_clear (cfg_we),
    .out_free  (out_free),
    .done      (done),
    .res       (res)
  );

  // zero is taken as one, oversize saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(CAP_MAX);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        capacity <= CW'(1);
      end else if (32'(cfg_wdata) > 32'(CAP_MAX)) begin
        capacity <= CW'(CAP_MAX);
      end else begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_q <= res;
    end
  end

  assign rsp.ok        = res_q.ok;
  assign rsp.data      = res_q.data;
  assign rsp.position  = res_q.position;
  assign rsp.occupancy = res_q.occupancy;

  a_clear_resp: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.cmd == cfws_pkg::CMD_CLEAR
    |=> rsp.valid && rsp.ok && rsp.occupancy == '0)
    else $error("clear request did not give an empty-queue response");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ok |-> rsp.data == '0 && rsp.position == '0)
    else $error("failed request carries data or position");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.position != '0 |-> rsp.position <= rsp.occupancy)
    else $error("search position beyond occupancy");

endmodule

>>> sim/cfws_reply_checker.sv
`timescale 1ns / 1ps
// cfws_reply_checker: watches the request, response and capacity-write ports of
// circular_fifo_with_search, predicts each response and compares it field by field.
// Depends on cfws_pkg and the channel interfaces in cfws_if.
module cfws_reply_checker #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  cfws_req_if                        req,
  cfws_rsp_if                        rsp,
  input  logic                       cfg_we,
  input  logic [cfws_pkg::CNT_W-1:0] cfg_wdata,
  output int                         replies_due,
  output int                         mismatches,
  output int                         replies_checked
);

  localparam int CNT_W  = cfws_pkg::CNT_W;
  localparam int DATA_W = cfws_pkg::DATA_W;
  localparam int CMD_W  = cfws_pkg::CMD_W;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] slots [DEPTH];
  logic [IDX_W-1:0]  head_q;
  logic [IDX_W-1:0]  tail_q;
  logic [CNT_W-1:0]  fill_q;
  logic [CNT_W-1:0]  cap_q;
  cfws_pkg::res_t    awaited_replies [$];
  int                n_bad = 0;
  int                n_seen = 0;

  // wrap at the configured capacity, not at the storage depth
  function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] idx);
    if (int'(idx) + 1 >= int'(cap_q)) return '0;
    return idx + 1'b1;
  endfunction

  function automatic void empty_queue();
    head_q = '0;
    tail_q = '0;
    fill_q = '0;
  endfunction

  function automatic cfws_pkg::res_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [DATA_W-1:0] word);
    cfws_pkg::res_t   r;
    logic [IDX_W-1:0] p;
    r.ok       = 1'b1;
    r.data     = '0;
    r.position = '0;
    case (cmd)
      cfws_pkg::CMD_PUSH: begin
        if (fill_q >= cap_q) begin
          r.ok = 1'b0;
        end else begin
          slots[tail_q] = word;
          tail_q = step_index(tail_q);
          fill_q = fill_q + 1'b1;
        end
      end
      cfws_pkg::CMD_POP: begin
        if (fill_q == '0) begin
          r.ok = 1'b0;
        end else begin
          r.data = slots[head_q];
          head_q = step_index(head_q);
          fill_q = fill_q - 1'b1;
        end
      end
      cfws_pkg::CMD_SEARCH: begin
        p = head_q;
        for (int n = 1; n <= int'(fill_q); n++) begin
          if (slots[p] == word) begin
            r.position = n[CNT_W-1:0];
            break;
          end
          p = step_index(p);
        end
      end
      default: begin
        empty_queue();
      end
    endcase
    r.occupancy = fill_q;
    return r;
  endfunction

  always @(posedge clk) begin
    cfws_pkg::res_t got;
    cfws_pkg::res_t want;
    if (rst) begin
      cap_q = CNT_W'(DEPTH);
      empty_queue();
      awaited_replies.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.ok        = rsp.ok;
        got.data      = rsp.data;
        got.position  = rsp.position;
        got.occupancy = rsp.occupancy;
        if (awaited_replies.size() == 0) begin
          $error("response with no request pending: ok %0d data %0d position %0d occupancy %0d",
                 got.ok, got.data, got.position, got.occupancy);
          n_bad++;
        end else begin
          want = awaited_replies.pop_front();
          n_seen++;
          if (got.ok !== want.ok) begin
            $error("ok mismatch: expected %0d, actual %0d", want.ok, got.ok);
            n_bad++;
          end
          if (got.data !== want.data) begin
            $error("data mismatch: expected %0d, actual %0d", want.data, got.data);
            n_bad++;
          end
          if (got.position !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d", want.position, got.position);
            n_bad++;
          end
          if (got.occupancy !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d",
                   want.occupancy, got.occupancy);
            n_bad++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_wdata == '0) cap_q = CNT_W'(1);
        else if (int'(cfg_wdata) > DEPTH) cap_q = CNT_W'(DEPTH);
        else cap_q = cfg_wdata;
        empty_queue();
      end
      if (req.valid && req.ready) begin
        awaited_replies.push_back(apply_command(req.cmd, req.value));
      end
    end
    replies_due     <= awaited_replies.size();
    mismatches      <= n_bad;
    replies_checked <= n_seen;
  end

endmodule

>>> sim/circular_fifo_with_search_tb.sv
`timescale 1ns / 1ps
// circular_fifo_with_search_tb: clock, reset, request stimulus and verdict for
// circular_fifo_with_search. Depends on cfws_pkg, cfws_if and cfws_reply_checker.
module circular_fifo_with_search_tb;

  localparam int DEPTH  = 1024;
  localparam int CNT_W  = cfws_pkg::CNT_W;
  localparam int DATA_W = cfws_pkg::DATA_W;
  localparam int CMD_W  = cfws_pkg::CMD_W;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  int send_idle_pct = 22;
  int rcv_idle_pct  = 57;
  int replies_due;
  int mismatches;
  int replies_checked;
  int cmd_tally [4];
  int cap_writes = 0;

  logic [DATA_W-1:0] word_pool [8];

  cfws_req_if req_ch ();
  cfws_rsp_if rsp_ch ();

  circular_fifo_with_search #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cfws_reply_checker #(.DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .replies_due     (replies_due),
    .mismatches      (mismatches),
    .replies_checked (replies_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= !rst && (int'($urandom_range(99)) >= rcv_idle_pct);
  end

  // valid is lowered only inside an idle gap, so back-to-back requests keep it high
  task automatic send_req(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= c;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    cmd_tally[c]++;
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] v);
    hold_until_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cap_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return word_pool[$urandom_range(7)];
      5:             return 32'h7fff_ffff;
      6:             return 32'h8000_0000;
      7:             return '0;
      8:             return '1;
      default:       return $urandom;
    endcase
  endfunction

  // small word pool so searches hit and duplicates sit in the queue
  task automatic random_burst(input int n);
    int               r;
    logic [CMD_W-1:0] c;
    foreach (word_pool[i]) word_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 42) c = cfws_pkg::CMD_PUSH;
      else if (r < 74) c = cfws_pkg::CMD_POP;
      else if (r < 96) c = cfws_pkg::CMD_SEARCH;
      else c = cfws_pkg::CMD_CLEAR;
      send_req(c, pick_word());
    end
  endtask

  // fill the full-depth queue, overflow it, hit the last slot, then wrap head and tail
  task automatic fill_to_top();
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] top_word;
    top_word = '0;
    for (int i = 0; i < DEPTH + 3; i++) begin
      w = ($urandom & 32'hffff_f800) | i;
      if (i == DEPTH - 1) top_word = w;
      send_req(cfws_pkg::CMD_PUSH, w);
    end
    send_req(cfws_pkg::CMD_SEARCH, top_word);
    send_req(cfws_pkg::CMD_SEARCH, $urandom | 32'h0000_07ff);
    for (int i = 0; i < 40; i++) send_req(cfws_pkg::CMD_POP, $urandom);
    for (int i = 0; i < 40; i++) send_req(cfws_pkg::CMD_PUSH, $urandom);
    send_req(cfws_pkg::CMD_PUSH, $urandom);
    send_req(cfws_pkg::CMD_SEARCH, top_word);
    send_req(cfws_pkg::CMD_CLEAR, $urandom);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd   = cfws_pkg::CMD_PUSH;
    req_ch.value = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue, extreme words, search hits and misses, clear
    send_req(cfws_pkg::CMD_POP, 32'h0000_0000);
    send_req(cfws_pkg::CMD_SEARCH, 32'h0000_0000);
    send_req(cfws_pkg::CMD_PUSH, 32'h7fff_ffff);
    send_req(cfws_pkg::CMD_PUSH, 32'h8000_0000);
    send_req(cfws_pkg::CMD_PUSH, 32'h0000_0000);
    send_req(cfws_pkg::CMD_PUSH, 32'hffff_ffff);
    send_req(cfws_pkg::CMD_SEARCH, 32'hffff_ffff);
    send_req(cfws_pkg::CMD_SEARCH, 32'h8000_0000);
    send_req(cfws_pkg::CMD_SEARCH, 32'h0000_3039);
    send_req(cfws_pkg::CMD_POP, 32'hffff_ffff);
    send_req(cfws_pkg::CMD_POP, 32'h0000_0000);
    send_req(cfws_pkg::CMD_CLEAR, 32'h0000_0000);
    send_req(cfws_pkg::CMD_POP, 32'h0000_0000);
    // zero capacity is taken as one
    set_capacity('0);
    send_req(cfws_pkg::CMD_PUSH, 32'h0000_0005);
    send_req(cfws_pkg::CMD_PUSH, 32'h0000_0006);
    send_req(cfws_pkg::CMD_SEARCH, 32'h0000_0005);
    send_req(cfws_pkg::CMD_SEARCH, 32'h0000_0006);
    send_req(cfws_pkg::CMD_POP, 32'h0000_0000);
    send_req(cfws_pkg::CMD_PUSH, 32'h0000_0007);
    send_req(cfws_pkg::CMD_POP, 32'h0000_0000);
    send_req(cfws_pkg::CMD_POP, 32'h0000_0000);
    set_capacity(11'd2);
    send_req(cfws_pkg::CMD_PUSH, 32'h1234_5678);
    send_req(cfws_pkg::CMD_PUSH, 32'h9abc_def0);
    send_req(cfws_pkg::CMD_PUSH, 32'h0bad_f00d);
    send_req(cfws_pkg::CMD_POP, 32'h0000_0000);
    send_req(cfws_pkg::CMD_PUSH, 32'h5555_aaaa);
    send_req(cfws_pkg::CMD_SEARCH, 32'h5555_aaaa);

    // random, sender idles less than receiver
    set_capacity(11'd3);
    random_burst(100);
    set_capacity(11'd1);
    random_burst(60);
    set_capacity(11'd16);
    random_burst(60);
    hold_until_drained();
    random_burst(60);

    // receiver idles less than sender; oversize write saturates to full depth
    send_idle_pct <= 57;
    rcv_idle_pct  <= 22;
    set_capacity('1);
    fill_to_top();
    set_capacity('0);
    random_burst(50);

    // no idling on either side
    send_idle_pct <= 0;
    rcv_idle_pct  <= 0;
    set_capacity(CNT_W'($urandom_range(64, 4)));
    random_burst(100);
    set_capacity(11'd7);
    random_burst(80);
    set_capacity(CNT_W'(DEPTH));
    random_burst(60);

    hold_until_drained();
    repeat (20) @(posedge clk);

    $display("Sent %0d push, %0d pop, %0d search and %0d clear requests",
             cmd_tally[cfws_pkg::CMD_PUSH], cmd_tally[cfws_pkg::CMD_POP],
             cmd_tally[cfws_pkg::CMD_SEARCH], cmd_tally[cfws_pkg::CMD_CLEAR]);
    $display("%0d capacity writes, %0d responses compared, %0d mismatches",
             cap_writes, replies_checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
